### rtl/art_pkg.sv
// Package for the ack retransmit tracker: payload structs, codes, sizes.
// No dependencies.
package art_pkg;
	localparam int SLOTS = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [1:0] OP_TRACK = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	localparam logic [3:0] RK_NEW     = 4'd0;
	localparam logic [3:0] RK_REFRESH = 4'd1;
	localparam logic [3:0] RK_FULL    = 4'd2;
	localparam logic [3:0] RK_ACKED   = 4'd3;
	localparam logic [3:0] RK_UNKNOWN = 4'd4;
	localparam logic [3:0] RK_RESEND  = 4'd5;
	localparam logic [3:0] RK_GIVEUP  = 4'd6;
	localparam logic [3:0] RK_DONE    = 4'd7;
	localparam logic [3:0] RK_PENDING = 4'd8;
	localparam logic [3:0] RK_NOTPEND = 4'd9;

	localparam logic REG_RETRY_LIMIT = 1'b0;
	localparam logic REG_BACKOFF     = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [47:0] dest_mac;
		logic [7:0]  packet_handle;
		logic [31:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  result_kind;
		logic [3:0]  slot_index;
		logic [7:0]  out_handle;
		logic [47:0] out_mac;
		logic        last_result;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic                load;      // capture input item, clear walk index
		logic                step;      // advance walk index
		logic                rd;        // register slot index into read stage
		logic                mark_hit;  // remember current slot as match
		logic                mark_free; // remember current slot as first free
		logic                wr_new;    // write new entry at free slot
		logic                wr_refresh;
		logic                clr_hit;   // free matched slot
		logic                tick_apply;// apply tick decision to read slot
		logic                emit;      // load output register
		logic [3:0]          kind;
		logic                last;
	} art_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] operation;
		logic       walk_end;   // walk index at last slot
		logic       rd_valid;   // slot in read stage is valid
		logic       rd_match;   // its id matches
		logic       rd_expired;
		logic       rd_giveup;
		logic       hit_found;
		logic       free_found;
	} art_sts_t;
endpackage

### rtl/art_datapath.sv
// Datapath: slot table memories, walk index, tick arithmetic, output register.
// Depends on art_pkg.
module art_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  art_pkg::in_item_t   in_item,
	input  art_pkg::art_cmd_t   cmd,
	input  logic [7:0]          retry_limit,
	input  logic [15:0]         backoff_step_ms,
	input  logic                out_take,
	output art_pkg::art_sts_t   sts,
	output art_pkg::out_item_t  out_item,
	output logic                out_valid
);
	localparam int SW = art_pkg::SLOT_W;

	logic [art_pkg::SLOTS-1:0] valid_q;
	logic [63:0] id_hi_mem [art_pkg::SLOTS];
	logic [63:0] id_lo_mem [art_pkg::SLOTS];
	logic [47:0] mac_mem [art_pkg::SLOTS];
	logic [7:0]  hdl_mem [art_pkg::SLOTS];
	logic [31:0] time_mem [art_pkg::SLOTS];
	logic [7:0]  rty_mem [art_pkg::SLOTS];

	art_pkg::in_item_t item_q;
	logic [SW-1:0] idx_q, rd_idx_q, hit_q, free_q;
	logic hit_found_q, free_found_q;
	logic [63:0] rd_hi_q, rd_lo_q;
	logic [47:0] rd_mac_q;
	logic [7:0]  rd_hdl_q, rd_rty_q;
	logic [31:0] rd_time_q;
	logic [31:0] elapsed, wait_ms;

	// registered reads from the slot memories
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_hi_q   <= id_hi_mem[idx_q];
			rd_lo_q   <= id_lo_mem[idx_q];
			rd_mac_q  <= mac_mem[idx_q];
			rd_hdl_q  <= hdl_mem[idx_q];
			rd_time_q <= time_mem[idx_q];
			rd_rty_q  <= rty_mem[idx_q];
		end
		if (cmd.wr_new) begin
			id_hi_mem[free_q] <= item_q.id_high;
			id_lo_mem[free_q] <= item_q.id_low;
			hdl_mem[free_q]   <= item_q.packet_handle;
			rty_mem[free_q]   <= 8'd0;
		end
		if (cmd.wr_new || cmd.wr_refresh) begin
			mac_mem[cmd.wr_new ? free_q : hit_q]  <= item_q.dest_mac;
			time_mem[cmd.wr_new ? free_q : hit_q] <= item_q.time_ms;
		end else if (cmd.tick_apply && !sts.rd_giveup) begin
			time_mem[rd_idx_q] <= item_q.time_ms;
			rty_mem[rd_idx_q]  <= rd_rty_q + 8'd1;
		end
		if (cmd.load)
			item_q <= in_item;
	end

	assign elapsed = item_q.time_ms - rd_time_q;
	assign wait_ms = 32'(backoff_step_ms) * (32'(rd_rty_q) + 32'd1);

	always_comb begin
		sts.operation  = item_q.operation;
		sts.walk_end   = (idx_q == SW'(art_pkg::SLOTS - 1));
		sts.rd_valid   = valid_q[rd_idx_q];
		sts.rd_match   = (rd_hi_q == item_q.id_high) && (rd_lo_q == item_q.id_low);
		sts.rd_expired = (elapsed >= wait_ms);
		sts.rd_giveup  = (rd_rty_q >= retry_limit);
		sts.hit_found  = hit_found_q;
		sts.free_found = free_found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			rd_idx_q     <= '0;
			hit_q        <= '0;
			free_q       <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.step)
				idx_q <= idx_q + SW'(1);
			if (cmd.rd)
				rd_idx_q <= idx_q;
			if (cmd.mark_hit) begin
				hit_q       <= rd_idx_q;
				hit_found_q <= 1'b1;
			end
			if (cmd.mark_free) begin
				free_q       <= rd_idx_q;
				free_found_q <= 1'b1;
			end
			if (cmd.wr_new)
				valid_q[free_q] <= 1'b1;
			if (cmd.clr_hit)
				valid_q[hit_q] <= 1'b0;
			if (cmd.tick_apply && sts.rd_giveup)
				valid_q[rd_idx_q] <= 1'b0;
			if (cmd.emit)
				out_valid <= 1'b1;
			else if (out_take)
				out_valid <= 1'b0;
		end
	end

	// output register; unused fields held at zero
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item.result_kind <= cmd.kind;
			out_item.last_result <= cmd.last;
			out_item.slot_index  <= '0;
			out_item.out_handle  <= '0;
			out_item.out_mac     <= '0;
			case (cmd.kind)
				art_pkg::RK_NEW:
					out_item.slot_index <= 4'(free_q);
				art_pkg::RK_REFRESH, art_pkg::RK_ACKED, art_pkg::RK_PENDING:
					out_item.slot_index <= 4'(hit_q);
				art_pkg::RK_RESEND: begin
					out_item.slot_index <= 4'(rd_idx_q);
					out_item.out_handle <= rd_hdl_q;
					out_item.out_mac    <= rd_mac_q;
				end
				art_pkg::RK_GIVEUP: begin
					out_item.slot_index <= 4'(rd_idx_q);
					out_item.out_mac    <= rd_mac_q;
				end
				default: ;
			endcase
		end
	end
endmodule

### rtl/art_ctrl.sv
// Controller: sequences the slot walk for each operation and result emission.
// Depends on art_pkg.
module art_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_busy,  // output register holds an item that is not being taken
	input  art_pkg::art_sts_t  sts,
	output logic               in_rdy,
	output art_pkg::art_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1; // issue read of walk slot
	localparam logic [2:0] S_EVAL = 3'd2; // evaluate read slot
	localparam logic [2:0] S_EMIT = 3'd3; // tick result waits for output
	localparam logic [2:0] S_FIN  = 3'd4; // final result of the item

	logic [2:0] state_q, state_d;
	logic last_q, last_d;

	assign in_rdy = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		last_d  = last_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd   = 1'b1;
				last_d   = sts.walk_end;
				cmd.step = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				if (sts.operation == art_pkg::OP_TICK) begin
					if (sts.rd_valid && sts.rd_expired)
						state_d = S_EMIT;
					else
						state_d = last_q ? S_FIN : S_READ;
				end else begin
					if (sts.rd_valid && sts.rd_match && !sts.hit_found)
						cmd.mark_hit = 1'b1;
					if (!sts.rd_valid && !sts.free_found)
						cmd.mark_free = 1'b1;
					state_d = last_q ? S_FIN : S_READ;
				end
			end
			S_EMIT: begin
				if (!out_busy) begin
					cmd.emit       = 1'b1;
					cmd.kind       = sts.rd_giveup ? art_pkg::RK_GIVEUP
						: art_pkg::RK_RESEND;
					cmd.tick_apply = 1'b1;
					state_d        = last_q ? S_FIN : S_READ;
				end
			end
			S_FIN: begin
				if (!out_busy) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
					case (sts.operation)
						art_pkg::OP_TRACK: begin
							if (sts.hit_found) begin
								cmd.kind       = art_pkg::RK_REFRESH;
								cmd.wr_refresh = 1'b1;
							end else if (sts.free_found) begin
								cmd.kind   = art_pkg::RK_NEW;
								cmd.wr_new = 1'b1;
							end else
								cmd.kind = art_pkg::RK_FULL;
						end
						art_pkg::OP_ACK: begin
							cmd.kind    = sts.hit_found ? art_pkg::RK_ACKED
								: art_pkg::RK_UNKNOWN;
							cmd.clr_hit = sts.hit_found;
						end
						art_pkg::OP_QUERY:
							cmd.kind = sts.hit_found ? art_pkg::RK_PENDING
								: art_pkg::RK_NOTPEND;
						default:
							cmd.kind = art_pkg::RK_DONE;
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end
endmodule

### rtl/ack_retransmit_tracker_top.sv
// Top level of the ack retransmit tracker: config registers, controller, datapath.
// Depends on art_pkg, art_ctrl, art_datapath.
//
// Holds up to 16 packets awaiting acknowledgement. Each input item (track, ack,
// tick, query) walks all 16 slots in turn through a single registered memory
// read port; results queue behind a one-deep output register, and emitting a
// result waits while it is full and not taken. Track, ack and query give one
// result; tick gives one resend or give-up per expired slot then a done item
// with last_result set. Slot contents other than valid bits are not reset.
// Configuration (retry_limit index 0, backoff_step_ms index 1) is to be written
// by the user only while idle; the block itself does not enforce this.
module ack_retransmit_tracker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  art_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output art_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	art_pkg::art_cmd_t cmd;
	art_pkg::art_sts_t sts;
	logic [7:0]  retry_limit_q;
	logic [15:0] backoff_q;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= 8'd3;
			backoff_q     <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				art_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[7:0];
				art_pkg::REG_BACKOFF:     backoff_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_busy (out_valid && !out_ready),
		.sts      (sts),
		.in_rdy   (in_ready),
		.cmd      (cmd)
	);

	art_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_item         (in_data),
		.cmd             (cmd),
		.retry_limit     (retry_limit_q),
		.backoff_step_ms (backoff_q),
		.out_take        (out_ready),
		.sts             (sts),
		.out_item        (out_data),
		.out_valid       (out_valid)
	);
endmodule

### rtl/art_checker.sv
// Port-level checker for the ack retransmit tracker, bound to the top level.
// Depends on art_pkg.
module art_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input art_pkg::out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second item during a walk");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == art_pkg::RK_DONE |-> out_data.last_result)
		else $error("done item without last flag");
	a_tick_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_kind == art_pkg::RK_RESEND ||
		out_data.result_kind == art_pkg::RK_GIVEUP) |-> !out_data.last_result)
		else $error("tick slot item flagged last");
endmodule

bind ack_retransmit_tracker_top art_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
